@@ sv/operand_multiply_decimal_display_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the display unit checkers.
// ----------------------------------------------------------------------------
`ifndef OPERAND_MULTIPLY_DECIMAL_DISPLAY_UNIT_MACROS_SVH
`define OPERAND_MULTIPLY_DECIMAL_DISPLAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define OMDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define OMDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/omdd_pkg.sv @@
// ----------------------------------------------------------------------------
// omdd_pkg
// Shared types, constants and the segment encoder of the display unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package omdd_pkg;

    localparam int SWITCH_BITS = 10;
    localparam int KEY_W       = 4;
    localparam int DIGITS      = 6;
    localparam int DISP_POS    = 6;
    localparam int VAL_W       = 2 * SWITCH_BITS;
    localparam int MUL_CNT_W   = (SWITCH_BITS > 1) ? $clog2(SWITCH_BITS) : 1;
    localparam int CONV_CNT_W  = $clog2(VAL_W);
    localparam int IN_DATA_W   = ((SWITCH_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 64;

    localparam logic [KEY_W-1:0] KEY_LOAD_A  = 4'd7;
    localparam logic [KEY_W-1:0] KEY_LOAD_B  = 4'd11;
    localparam logic [KEY_W-1:0] KEY_PRODUCT = 4'd13;

    localparam logic [7:0] SEG_ZERO = 8'hC0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CONV,
        ST_DONE
    } omdd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } omdd_unit_sts_t;

    typedef logic [DIGITS-1:0][3:0] omdd_bcd_t;

    // Active-low segments, bit 7 is the decimal point (off)
    function automatic logic [7:0] seg_encode(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

@@ sv/operand_multiply_decimal_display_unit.sv @@
// ----------------------------------------------------------------------------
// operand_multiply_decimal_display_unit
// Operand load, multiply and six-digit seven-segment display of switch values.
// ----------------------------------------------------------------------------
// Load A / load B run the bit-serial decimal converter (20 steps) on the switch
// value, a product runs the bit-serial multiplier (10 steps) and then the converter,
// other key patterns go straight to the output. One item at a time: input reopens
// in the same cycle as m_tvalid rises, and stays closed while a stalled result
// still occupies the output register.
// Reset clears operands to zero and the display to six zero digits.
`timescale 1ns / 1ps

module operand_multiply_decimal_display_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [omdd_pkg::IN_DATA_W-1:0]      s_tdata,  // switches, zero pad
    input  logic [omdd_pkg::KEY_W-1:0]          s_tuser,  // keys
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [omdd_pkg::OUT_DATA_W-1:0]     m_tdata   // leds, hex_low_word,
                                                          // hex_high_word, zero pad
);
    import omdd_pkg::*;

    omdd_state_t            state_reg, state_next;
    logic [SWITCH_BITS-1:0] op_a_reg,  op_a_next;
    logic [SWITCH_BITS-1:0] op_b_reg,  op_b_next;
    logic [SWITCH_BITS-1:0] sw_reg,    sw_next;
    logic [31:0]            shown_low_reg,  shown_low_next;
    logic [15:0]            shown_high_reg, shown_high_next;
    logic                   m_tvalid_reg,   m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg,    m_tdata_next;

    logic                   mul_start;
    logic [VAL_W-1:0]       product;
    omdd_unit_sts_t         mul_sts;
    logic                   conv_start;
    logic [VAL_W-1:0]       conv_value;
    omdd_bcd_t              digits;
    omdd_unit_sts_t         conv_sts;
    logic [DISP_POS-1:0][7:0] seg;
    logic [SWITCH_BITS-1:0] sw_in;

    assign sw_in = s_tdata[SWITCH_BITS-1:0];

    omdd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .product (product),
        .sts     (mul_sts)
    );

    omdd_b2bcd u_b2bcd (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (conv_start),
        .value   (conv_value),
        .digits  (digits),
        .sts     (conv_sts)
    );

    // Positions past the converted digits show zero
    always_comb
    begin
        for (int p = 0; p < DISP_POS; p++)
        begin
            if (p < DIGITS)
            begin
                seg[p] = seg_encode(digits[p]);
            end
            else
            begin
                seg[p] = SEG_ZERO;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        sw_next         = sw_reg;
        shown_low_next  = shown_low_reg;
        shown_high_next = shown_high_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mul_start       = 1'b0;
        conv_start      = 1'b0;
        conv_value      = product;
        s_tready        = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                conv_value = {{(VAL_W-SWITCH_BITS){1'b0}}, sw_in};
                if (s_tvalid)
                begin
                    sw_next = sw_in;
                    priority if (s_tuser == KEY_LOAD_A)
                    begin
                        op_a_next  = sw_in;
                        conv_start = 1'b1;
                        state_next = ST_CONV;
                    end
                    else if (s_tuser == KEY_LOAD_B)
                    begin
                        op_b_next  = sw_in;
                        conv_start = 1'b1;
                        state_next = ST_CONV;
                    end
                    else if (s_tuser == KEY_PRODUCT)
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        // Display holds its contents
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_sts.done)
                begin
                    conv_start = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_sts.done)
                begin
                    shown_low_next  = {seg[3], seg[2], seg[1], seg[0]};
                    shown_high_next = {seg[5], seg[4]};
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Advance only once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_DATA_W-58){1'b0}}, shown_high_reg,
                                     shown_low_reg, sw_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_a_reg       <= '0;
            op_b_reg       <= '0;
            shown_low_reg  <= {4{SEG_ZERO}};
            shown_high_reg <= {2{SEG_ZERO}};
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_a_reg       <= op_a_next;
            op_b_reg       <= op_b_next;
            shown_low_reg  <= shown_low_next;
            shown_high_reg <= shown_high_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_reg      <= sw_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/omdd_mul.sv @@
// ----------------------------------------------------------------------------
// omdd_mul
// Shift-add multiplier: one adder, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module omdd_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [omdd_pkg::SWITCH_BITS-1:0]    op_a,
    input  logic [omdd_pkg::SWITCH_BITS-1:0]    op_b,
    output logic [omdd_pkg::VAL_W-1:0]          product,
    output omdd_pkg::omdd_unit_sts_t            sts
);
    import omdd_pkg::*;

    logic [VAL_W-1:0]       prod_reg,   prod_next;
    logic [VAL_W-1:0]       mcand_reg,  mcand_next;
    logic [SWITCH_BITS-1:0] mplier_reg, mplier_next;
    logic [MUL_CNT_W-1:0]   cnt_reg,    cnt_next;
    logic                   busy_reg,   busy_next;
    logic                   done_reg,   done_next;

    always_comb
    begin
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            prod_next   = '0;
            mcand_next  = {{(VAL_W-SWITCH_BITS){1'b0}}, op_a};
            mplier_next = op_b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(SWITCH_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product  = prod_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

@@ sv/omdd_b2bcd.sv @@
// ----------------------------------------------------------------------------
// omdd_b2bcd
// Shift-and-add-3 binary to decimal converter, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module omdd_b2bcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [omdd_pkg::VAL_W-1:0]  value,
    output omdd_pkg::omdd_bcd_t         digits,
    output omdd_pkg::omdd_unit_sts_t    sts
);
    import omdd_pkg::*;

    logic [VAL_W-1:0]      val_reg,  val_next;
    omdd_bcd_t             bcd_reg,  bcd_next;
    omdd_bcd_t             adj;
    logic [CONV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // Add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        val_next  = val_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Carry out of the top digit is dropped: keeps the low digits only
            bcd_next[0] = {adj[0][2:0], val_reg[VAL_W-1]};
            for (int i = 1; i < DIGITS; i++)
            begin
                bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
            val_next = val_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CONV_CNT_W'(VAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        bcd_reg <= bcd_next;
    end

    assign digits   = bcd_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

@@ sv/omdd_chk.sv @@
// ----------------------------------------------------------------------------
// omdd_chk
// Port-level checks of the display unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "operand_multiply_decimal_display_unit_macros.svh"

module omdd_chk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [omdd_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [omdd_pkg::KEY_W-1:0]          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [omdd_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import omdd_pkg::*;

    // One item in flight: input closes right after an accept
    `OMDD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")

    // A new result only follows a cycle in which the input was closed
    `OMDD_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result without item")

    // Padding above the display words stays zero
    `OMDD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[63:58] == 6'd0, "output padding not zero")

    // Stalled result holds
    `OMDD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")

endmodule

bind operand_multiply_decimal_display_unit omdd_chk u_omdd_chk (.*);
